// File: sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define UHLF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uhlf assertion failed");

// next-cycle implication, disabled while reset is asserted
`define UHLF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uhlf assertion failed");

`endif

// File: sv/uhlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhlf_pkg
// Types and constants of the sync-pair, length-prefixed frame receiver.
// ----------------------------------------------------------------------------
package uhlf_pkg;

  localparam int BYTE_W = 8;
  localparam int IDX_W = 4;
  localparam int FUNC_W = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int BUF_DEPTH_DEF = 16;
  localparam int MAX_INDEX_DEF = 8;

  // slot that holds the payload length, and its bias in the end compare
  localparam logic [IDX_W-1:0] LEN_SLOT = 4'd2;
  localparam logic [BYTE_W:0] LEN_OFFSET = 9'd2;

  localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd85;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RST = 8'd170;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RX   = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic {
    CFG_SYNC_SECOND = 1'b0,
    CFG_SYNC_FIRST  = 1'b1
  } cfg_reg_e;

  // request from the control path to the frame store
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

endpackage

// File: sv/uhlf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhlf_in_if / uhlf_out_if
// Valid/ready channels carrying requests into and results out of the framer.
// ----------------------------------------------------------------------------
interface uhlf_in_if;
  logic                          valid;
  logic                          ready;
  logic [uhlf_pkg::FUNC_W-1:0]   func;
  logic [uhlf_pkg::BYTE_W-1:0]   rx_byte;
  logic [uhlf_pkg::IDX_W-1:0]    read_index;

  modport source (output valid, output func, output rx_byte, output read_index,
                  input ready);
  modport sink (input valid, input func, input rx_byte, input read_index,
                output ready);
endinterface

interface uhlf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          frame_ready;
  logic                          frame_done;
  logic                          frame_aborted;
  logic [uhlf_pkg::IDX_W-1:0]    fill_index;
  logic [uhlf_pkg::BYTE_W-1:0]   read_data;

  modport source (output valid, output frame_ready, output frame_done,
                  output frame_aborted, output fill_index, output read_data,
                  input ready);
  modport sink (input valid, input frame_ready, input frame_done,
                input frame_aborted, input fill_index, input read_data,
                output ready);
endinterface

// File: sv/uhlf_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhlf_store
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uhlf_store #(
  parameter int BUF_DEPTH = uhlf_pkg::BUF_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  uhlf_pkg::store_req_t        req_i,
  output logic [uhlf_pkg::BYTE_W-1:0] rdata_o
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [uhlf_pkg::BYTE_W-1:0] mem [BUF_DEPTH];
  logic [uhlf_pkg::BYTE_W-1:0] rdata_q;
  logic [AW-1:0]               waddr;
  logic [AW-1:0]               raddr;

  assign waddr = AW'(req_i.waddr);
  assign raddr = AW'(req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/uart_header_length_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_header_length_framer
// Hunts a two-byte sync pair in a byte stream and collects a length-prefixed
// frame, with acknowledge and buffer read requests on the same channel.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one request per handshake: receive a byte, acknowledge the
//   waiting frame, read a buffer slot, or no operation.
//   out_o returns exactly one result per request, in order.
//   the APB port holds the two sync byte values; write it only while idle.
// latency and throughput:
//   a result shows on out_o the cycle after its request is accepted; one request
//   per cycle unless stalled; the state update and the store write are a single
//   registered pass, and the store read port is registered with the result.
// reset:
//   byte history, frame state, index and ready flag clear; sync bytes return
//   to 0xAA then 0x55. the frame store is not cleared; slots are valid once
//   a frame has written them.
// stall:
//   a result waits in the output register while out_o is not ready; a new
//   request is taken in the same cycle the waiting result leaves.
// ----------------------------------------------------------------------------
module uart_header_length_framer #(
  parameter int BUF_DEPTH = uhlf_pkg::BUF_DEPTH_DEF,
  parameter int MAX_INDEX = uhlf_pkg::MAX_INDEX_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  uhlf_in_if.sink                         in_i,
  uhlf_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uhlf_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [uhlf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [uhlf_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int BW = uhlf_pkg::BYTE_W;
  localparam int IW = uhlf_pkg::IDX_W;

  // configuration
  logic [BW-1:0] sync_second_q;
  logic [BW-1:0] sync_first_q;
  logic          cfg_wr;
  uhlf_pkg::cfg_reg_e cfg_sel;

  // frame state
  logic [BW-1:0] newest_q, newest_d;
  logic          in_frame_q, in_frame_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          rdy_q, rdy_d;
  logic [BW-1:0] slot0_q, slot0_d;
  logic [BW-1:0] len_q, len_d;

  // result register
  logic          out_valid_q;
  logic          done_q, done_d;
  logic          abort_q, abort_d;
  logic          rd_mem_q, rd_mem_d;
  logic          rd_zero_q, rd_zero_d;
  logic [BW-1:0] store_rdata;

  logic          accept;
  logic          sync_hit;
  logic [IW-1:0] idx_inc;
  logic [IW-1:0] idx_new;
  logic [BW-1:0] len_eff;
  logic          rd_in_range;
  uhlf_pkg::store_req_t store_req;

  // ---------------------------------------------------------------- APB port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = uhlf_pkg::cfg_reg_e'(paddr[2]);

  always_comb begin
    unique case (cfg_sel)
      uhlf_pkg::CFG_SYNC_SECOND: prdata = uhlf_pkg::APB_DATA_W'(sync_second_q);
      uhlf_pkg::CFG_SYNC_FIRST:  prdata = uhlf_pkg::APB_DATA_W'(sync_first_q);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_second_q <= uhlf_pkg::SYNC_SECOND_RST;
      sync_first_q  <= uhlf_pkg::SYNC_FIRST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        uhlf_pkg::CFG_SYNC_SECOND: sync_second_q <= pwdata[BW-1:0];
        uhlf_pkg::CFG_SYNC_FIRST:  sync_first_q  <= pwdata[BW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------- step logic
  // the byte before the incoming one is the one held in newest_q
  assign sync_hit = in_frame_q ||
                    (in_i.rx_byte == sync_second_q && newest_q == sync_first_q);
  assign idx_inc  = idx_q + IW'(1);
  assign idx_new  = (32'(idx_inc) >= BUF_DEPTH) ? '0 : idx_inc;
  // length byte lands in this step when the new index is the length slot
  assign len_eff  = (idx_new == uhlf_pkg::LEN_SLOT) ? in_i.rx_byte : len_q;
  assign rd_in_range = 32'(in_i.read_index) < BUF_DEPTH;

  always_comb begin
    newest_d   = newest_q;
    in_frame_d = in_frame_q;
    idx_d      = idx_q;
    rdy_d      = rdy_q;
    slot0_d    = slot0_q;
    len_d      = len_q;
    done_d     = 1'b0;
    abort_d    = 1'b0;
    rd_mem_d   = 1'b0;
    rd_zero_d  = 1'b0;
    store_req  = '0;
    store_req.waddr = idx_new;
    store_req.wdata = in_i.rx_byte;
    store_req.raddr = in_i.read_index;

    unique case (uhlf_pkg::func_e'(in_i.func))
      uhlf_pkg::FUNC_RX: begin
        newest_d = in_i.rx_byte;
        if (sync_hit) begin
          in_frame_d = 1'b1;
          // slot 0 lives in its own register so completion can load it too
          if (idx_new == '0) begin
            slot0_d = in_i.rx_byte;
          end else begin
            store_req.we = accept;
          end
          if (idx_new == uhlf_pkg::LEN_SLOT) begin
            len_d = in_i.rx_byte;
          end
          if (idx_new > IW'(MAX_INDEX)) begin
            in_frame_d = 1'b0;
            rdy_d      = 1'b0;
            idx_d      = '0;
            abort_d    = 1'b1;
          end else if ((BW+1)'(idx_new) >= ({1'b0, len_eff} + uhlf_pkg::LEN_OFFSET))
          begin
            if (!rdy_q) begin
              slot0_d = sync_first_q;
              rdy_d   = 1'b1;
            end
            idx_d      = '0;
            in_frame_d = 1'b0;
            done_d     = 1'b1;
          end else begin
            idx_d = idx_new;
          end
        end
      end
      uhlf_pkg::FUNC_ACK: begin
        rdy_d = 1'b0;
      end
      uhlf_pkg::FUNC_READ: begin
        rd_zero_d    = in_i.read_index == '0;
        rd_mem_d     = rd_in_range && (in_i.read_index != '0);
        store_req.re = accept && rd_mem_d;
      end
      uhlf_pkg::FUNC_NOP: begin
      end
      default: begin
      end
    endcase
  end

  uhlf_store #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_uhlf_store (
    .clk_i  (clk_i),
    .req_i  (store_req),
    .rdata_o(store_rdata)
  );

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      newest_q    <= '0;
      in_frame_q  <= 1'b0;
      idx_q       <= '0;
      rdy_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        newest_q   <= newest_d;
        in_frame_q <= in_frame_d;
        idx_q      <= idx_d;
        rdy_q      <= rdy_d;
      end
      out_valid_q <= accept || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      slot0_q   <= slot0_d;
      len_q     <= len_d;
      done_q    <= done_d;
      abort_q   <= abort_d;
      rd_mem_q  <= rd_mem_d;
      rd_zero_q <= rd_zero_d;
    end
  end

  // ---------------------------------------------------------------- outputs
  // the state registers already hold the post-step values of the waiting result
  assign out_o.valid         = out_valid_q;
  assign out_o.frame_ready   = rdy_q;
  assign out_o.frame_done    = done_q;
  assign out_o.frame_aborted = abort_q;
  assign out_o.fill_index    = idx_q;
  assign out_o.read_data     = rd_mem_q  ? store_rdata :
                               rd_zero_q ? slot0_q     : '0;

endmodule

// File: sv/uhlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhlf_checker
// Port-level checks on the framer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uhlf_checker #(
  parameter int MAX_INDEX = uhlf_pkg::MAX_INDEX_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       frame_ready_i,
  input logic                       frame_done_i,
  input logic                       frame_aborted_i,
  input logic [uhlf_pkg::IDX_W-1:0] fill_index_i
);

  logic done_and_abort;
  logic abort_ok;
  logic index_ok;

  assign done_and_abort = frame_done_i && frame_aborted_i;
  assign abort_ok       = !frame_ready_i && fill_index_i == '0;
  assign index_ok       = fill_index_i <= uhlf_pkg::IDX_W'(MAX_INDEX) &&
                          (!frame_done_i || fill_index_i == '0);

  // a waiting result is not withdrawn
  `UHLF_ASSERT_NXT(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  // a frame cannot both end and be dropped by the same byte
  `UHLF_ASSERT_IMP(a_done_xor_abort, clk_i, rst_ni, out_valid_i, !done_and_abort)

  // a drop clears the ready flag and returns to hunting
  `UHLF_ASSERT_IMP(a_abort_state, clk_i, rst_ni, out_valid_i && frame_aborted_i, abort_ok)

  // the fill index never passes the limit, and an ended frame leaves it at zero
  `UHLF_ASSERT_IMP(a_index_bound, clk_i, rst_ni, out_valid_i, index_ok)

endmodule

bind uart_header_length_framer uhlf_checker #(
  .MAX_INDEX(MAX_INDEX)
) u_uhlf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .frame_ready_i  (out_o.frame_ready),
  .frame_done_i   (out_o.frame_done),
  .frame_aborted_i(out_o.frame_aborted),
  .fill_index_i   (out_o.fill_index)
);
